/* design/stereo_six_band_svf_eq_core_macros.svh */
// Assertion macros shared by the equaliser modules.
`ifndef STEREO_SIX_BAND_SVF_EQ_CORE_MACROS_SVH
`define STEREO_SIX_BAND_SVF_EQ_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/sse_pkg.sv */
// Shared types and constants for the stereo state-variable filter equaliser.
`timescale 1ns / 1ps
package sse_pkg;
    localparam int COEF_REGS = 6;
    localparam logic [2:0] REG_ENABLE = 3'd0;

    typedef enum logic [3:0] {
        OP_LOAD, OP_HP1, OP_HP2, OP_HP3, OP_HP4, OP_BP1, OP_BP2, OP_LP1, OP_LP2,
        OP_Z1, OP_Z2, OP_Y1, OP_Y2
    } op_t;

    typedef struct packed {
        logic load_x;
        logic step;
        op_t  op;
        logic save;
    } dp_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction
endpackage

/* design/sse_datapath.sv */
// Shared multiplier datapath that runs one band step at a time.
`timescale 1ns / 1ps
`include "stereo_six_band_svf_eq_core_macros.svh"
module sse_datapath #(
    parameter int BAND_COUNT   = 6,
    parameter int SAMPLE_WIDTH = 24,
    parameter int IW           = $clog2(BAND_COUNT * 4)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sse_pkg::dp_cmd_t               cmd,
    input  logic [IW-1:0]                  base,
    input  logic [63:0]                    coef,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    output logic signed [SAMPLE_WIDTH-1:0] y_out
);
    localparam int DEPTH = BAND_COUNT * 4;
    logic signed [31:0] store_reg [DEPTH];
    logic [DEPTH-1:0]   vld_reg, vld_next;
    logic signed [31:0] x_reg, x_next, z1_reg, z1_next, z2_reg, z2_next;
    logic signed [39:0] t_reg, t_next;
    logic signed [31:0] hp_reg, hp_next, bp_reg, bp_next;
    logic signed [31:0] lp_reg, lp_next;
    logic signed [47:0] ghp_reg, ghp_next, gbp_reg, gbp_next;
    logic signed [56:0] p_reg, p_next;
    logic signed [39:0] ma;
    logic signed [16:0] mb;
    logic signed [16:0] g_s, g1_s, d_s, gm_s;
    logic signed [47:0] rnd;
    logic [4:0] sh;
    logic signed [SAMPLE_WIDTH-1:0] hi_c, lo_c;

    assign g_s  = {1'b0, coef[15:0]};
    assign g1_s = {1'b0, coef[31:16]};
    assign d_s  = {1'b0, coef[47:32]};
    assign gm_s = {coef[63], coef[63:48]};
    assign hi_c = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    assign lo_c = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    always_comb
    begin
        ma = '0;
        mb = '0;
        sh = 5'd14;
        case (cmd.op)
            sse_pkg::OP_HP1: begin ma = 40'(z1_reg); mb = g1_s; sh = 5'd12; end
            sse_pkg::OP_HP3: begin ma = t_reg; mb = d_s; sh = 5'd16; end
            sse_pkg::OP_BP1: begin ma = 40'(hp_reg); mb = g_s; end
            sse_pkg::OP_LP1: begin ma = 40'(bp_reg); mb = g_s; end
            sse_pkg::OP_Y1:  begin ma = 40'(bp_reg); mb = gm_s; end
            default: ;
        endcase
        p_next = ma * mb;
        rnd = 48'((p_reg + (57'sd1 <<< (sh - 5'd1))) >>> sh);
    end

    always_comb
    begin
        x_next = x_reg; z1_next = z1_reg; z2_next = z2_reg; t_next = t_reg;
        hp_next = hp_reg; bp_next = bp_reg; lp_next = lp_reg;
        ghp_next = ghp_reg; gbp_next = gbp_reg; vld_next = vld_reg;
        if (cmd.load_x)
            x_next = 32'(x_in);
        if (cmd.step)
        begin
            case (cmd.op)
                sse_pkg::OP_LOAD: begin
                    z1_next = vld_reg[base] ? store_reg[base] : '0;
                    z2_next = vld_reg[IW'(base + 1'b1)] ? store_reg[IW'(base + 1'b1)] : '0;
                end
                sse_pkg::OP_HP2: t_next = 40'(57'(x_reg) - ((p_reg + 57'sd2048) >>> 12)
                                         - 57'(z2_reg));
                sse_pkg::OP_HP3: ;
                sse_pkg::OP_HP4: hp_next = sse_pkg::sat32(48'((p_reg + 57'sd32768) >>> 16));
                sse_pkg::OP_BP2: begin
                    ghp_next = rnd;
                    bp_next = sse_pkg::sat32(rnd + 48'(z1_reg));
                end
                sse_pkg::OP_LP2: begin
                    gbp_next = rnd;
                    lp_next = sse_pkg::sat32(rnd + 48'(z2_reg));
                end
                sse_pkg::OP_Z1: z1_next = sse_pkg::sat32(ghp_reg + 48'(bp_reg));
                sse_pkg::OP_Z2: z2_next = sse_pkg::sat32(gbp_reg + 48'(lp_reg));
                sse_pkg::OP_Y2: x_next = sse_pkg::sat32(48'(x_reg) + rnd);
                default: ;
            endcase
        end
        if (cmd.save)
        begin
            vld_next[base] = 1'b1;
            vld_next[IW'(base + 1'b1)] = 1'b1;
        end
    end

    // The product for HP2 must use the 12-bit scale; p_reg is shared so HP2 is a pure add.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; z1_reg <= z1_next; z2_reg <= z2_next; t_reg <= t_next;
        hp_reg <= hp_next; bp_reg <= bp_next; lp_reg <= lp_next;
        ghp_reg <= ghp_next; gbp_reg <= gbp_next; p_reg <= p_next;
        if (cmd.save)
        begin
            store_reg[base] <= z1_reg;
            store_reg[IW'(base + 1'b1)] <= z2_reg;
        end
    end

    always_comb
    begin
        if (x_reg > 32'(hi_c)) y_out = hi_c;
        else if (x_reg < 32'(lo_c)) y_out = lo_c;
        else y_out = x_reg[SAMPLE_WIDTH-1:0];
    end

    `SSE_ASSERT_IMPL(a_save_even, clk, rst_n, cmd.save, base[0] == 1'b0)
    `SSE_ASSERT_NEXT(a_save_valid, clk, rst_n, cmd.save, vld_reg[$past(base)])
    `SSE_ASSERT_IMPL(a_no_mix, clk, rst_n, cmd.save, !cmd.step)
endmodule

/* design/sse_controller.sv */
// Sequencer that walks both channels through every band step by step, or just signals done when filtering is off.
`timescale 1ns / 1ps
`include "stereo_six_band_svf_eq_core_macros.svh"
module sse_controller #(
    parameter int BAND_COUNT = 6,
    parameter int IW         = $clog2(BAND_COUNT * 4)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             enable,
    output logic             busy,
    output logic             side,
    output logic             cap_left,
    output logic             done,
    output logic [IW-1:0]    base,
    output logic [$clog2(BAND_COUNT+1)-1:0] band,
    output sse_pkg::dp_cmd_t cmd
);
    typedef enum logic [2:0] {S_IDLE, S_LOADX, S_RUN, S_SAVE, S_CAP} state_t;
    localparam int BW = $clog2(BAND_COUNT + 1);
    state_t state_reg, state_next;
    sse_pkg::op_t op_reg, op_next;
    logic [BW-1:0] band_reg, band_next;
    logic side_reg, side_next;

    always_comb
    begin
        state_next = state_reg; op_next = op_reg; band_next = band_reg;
        side_next = side_reg;
        cmd = '{load_x: 1'b0, step: 1'b0, op: op_reg, save: 1'b0};
        cap_left = 1'b0; done = 1'b0;
        unique case (state_reg)
            S_IDLE: if (start)
            begin
                if (enable) begin state_next = S_LOADX; side_next = 1'b0; end
                else done = 1'b1;
            end
            S_LOADX: begin
                cmd.load_x = 1'b1; band_next = '0; op_next = sse_pkg::OP_LOAD;
                state_next = S_RUN;
            end
            S_RUN: begin
                cmd.step = 1'b1;
                if (op_reg == sse_pkg::OP_Y2) state_next = S_SAVE;
                else op_next = sse_pkg::op_t'(op_reg + 1'b1);
            end
            S_SAVE: begin
                cmd.save = 1'b1; op_next = sse_pkg::OP_LOAD;
                if (band_reg == BW'(BAND_COUNT - 1)) state_next = S_CAP;
                else begin band_next = band_reg + 1'b1; state_next = S_RUN; end
            end
            S_CAP: begin
                if (!side_reg)
                begin
                    cap_left = 1'b1; side_next = 1'b1; state_next = S_LOADX;
                end
                else
                begin
                    done = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; op_reg <= sse_pkg::OP_LOAD; band_reg <= '0;
            side_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; op_reg <= op_next; band_reg <= band_next;
            side_reg <= side_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign side = side_reg;
    assign band = band_reg;
    assign base = IW'({band_reg, side_reg, 1'b0});

    `SSE_ASSERT_IMPL(a_band_range, clk, rst_n, busy, band_reg < BW'(BAND_COUNT))
    `SSE_ASSERT_NEXT(a_done_idle, clk, rst_n, done && busy, !busy)
    `SSE_ASSERT_NEXT(a_cap_reload, clk, rst_n, cap_left, state_reg == S_LOADX)
endmodule

/* design/stereo_six_band_svf_eq_core.sv */
// Top level of the stereo six-band state-variable filter equaliser.
`timescale 1ns / 1ps
// One stereo word is taken at a time. With filtering on, each channel
// runs BAND_COUNT bands in turn on one shared multiplier; in bypass a
// word goes from the input registers straight to the output register.
// The result sits in an output register, and the next word is taken
// while it waits.
module stereo_six_band_svf_eq_core #(
    parameter int BAND_COUNT   = 6,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  logic signed [SAMPLE_WIDTH-1:0] right_in,
    input  logic                           end_of_block,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out,
    output logic                           end_of_block_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [63:0]                    cfg_data
);
    localparam int IW = $clog2(BAND_COUNT * 4);
    localparam int BW = $clog2(BAND_COUNT + 1);
    logic en_reg;
    logic [63:0] coef_reg [sse_pkg::COEF_REGS];
    logic signed [SAMPLE_WIDTH-1:0] l_reg, r_reg, lo_reg, ro_reg, y, y_l_reg;
    logic eob_reg, eobo_reg, ov_reg, pend_reg;
    logic start, busy, side, cap_left, done;
    logic [IW-1:0] base;
    logic [BW-1:0] band;
    logic [63:0] coef;
    sse_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;
    assign in_ready = !pend_reg;
    assign start = pend_reg && !busy && (!ov_reg || out_ready);
    assign coef = (32'(band) < sse_pkg::COEF_REGS) ? coef_reg[band[2:0]] : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0; ov_reg <= 1'b0; pend_reg <= 1'b0;
            for (int i = 0; i < sse_pkg::COEF_REGS; i++) coef_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == sse_pkg::REG_ENABLE) en_reg <= cfg_data[0];
                else if (32'(cfg_index) <= sse_pkg::COEF_REGS)
                    coef_reg[cfg_index - 3'd1] <= cfg_data;
            end
            if (in_valid && in_ready) pend_reg <= 1'b1;
            else if (done) pend_reg <= 1'b0;
            if (done) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            l_reg <= left_in; r_reg <= right_in; eob_reg <= end_of_block;
        end
        if (cap_left) y_l_reg <= y;
        if (done)
        begin
            lo_reg <= en_reg ? y_l_reg : l_reg;
            ro_reg <= en_reg ? y : r_reg;
            eobo_reg <= eob_reg;
        end
    end

    sse_controller #(.BAND_COUNT(BAND_COUNT)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .enable(en_reg), .busy(busy),
        .side(side), .cap_left(cap_left), .done(done), .base(base), .band(band),
        .cmd(cmd)
    );

    sse_datapath #(.BAND_COUNT(BAND_COUNT), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .base(base), .coef(coef),
        .x_in(side ? r_reg : l_reg), .y_out(y)
    );

    assign out_valid = ov_reg;
    assign left_out = lo_reg;
    assign right_out = ro_reg;
    assign end_of_block_out = eobo_reg;
endmodule

/* bench/tb.sv */
// Self-checking testbench for the stereo six-band state-variable filter equaliser core.
`timescale 1ns / 1ps
module tb;
    localparam logic [2:0] REG_ENABLE = sse_pkg::REG_ENABLE;
    localparam logic [2:0] REG_BAND0 = 3'd1;
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int NBANDS = 6;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [23:0] l;
        logic [23:0] r;
        logic        eob;
        bit          typed;
        logic [23:0] el;
        logic [23:0] er;
    } row_t;

    typedef struct {
        logic [23:0] l;
        logic [23:0] r;
        logic        eob;
    } stereo_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [23:0] left_in = '0;
    logic [23:0] right_in = '0;
    logic end_of_block = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [23:0] left_out;
    logic [23:0] right_out;
    logic end_of_block_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    stereo_six_band_svf_eq_core dut (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    bit          eq_on;
    logic [63:0] band_coef[NBANDS];
    longint      integ[NBANDS*4];
    stereo_t     pending_words[$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint svf_band(longint x, int b, int base);
        logic [63:0] c;
        longint g, g1, d, gm1, z1, z2, hp, bp, lp, ghp, gbp;
        c = band_coef[b];
        g = longint'({48'b0, c[15:0]});
        g1 = longint'({48'b0, c[31:16]});
        d = longint'({48'b0, c[47:32]});
        gm1 = longint'(signed'(c[63:48]));
        z1 = integ[base];
        z2 = integ[base+1];
        hp = clip32(round_shift((x - round_shift(g1 * z1, 12) - z2) * d, 16));
        ghp = round_shift(g * hp, 14);
        bp = clip32(ghp + z1);
        gbp = round_shift(g * bp, 14);
        lp = clip32(gbp + z2);
        integ[base] = clip32(ghp + bp);
        integ[base+1] = clip32(gbp + lp);
        return clip32(x + round_shift(bp * gm1, 14));
    endfunction

    function automatic logic [23:0] filter_channel(logic [23:0] raw, int side);
        longint x;
        x = longint'(signed'(raw));
        for (int b = 0; b < NBANDS; b++)
            x = svf_band(x, b, b*4 + side*2);
        if (x > 64'sd8388607) x = 64'sd8388607;
        if (x < -64'sd8388608) x = -64'sd8388608;
        return x[23:0];
    endfunction

    function automatic stereo_t predict_eq(stereo_t w);
        stereo_t o;
        o = w;
        if (eq_on) begin
            o.l = filter_channel(w.l, 0);
            o.r = filter_channel(w.r, 1);
        end
        return o;
    endfunction

    function automatic logic [63:0] audio_coef();
        int g, g1, d, gm1;
        real gr, twor;
        g = $urandom_range(12000, 64);
        g1 = g / 4 + $urandom_range(6000, 256);
        gr = g / 16384.0;
        twor = (g1 - g / 4) / 4096.0;
        d = int'(65536.0 / (1.0 + twor * gr + gr * gr));
        if (d > 65535) d = 65535;
        gm1 = int'($urandom_range(36000, 0)) - 12000;
        return {gm1[15:0], d[15:0], g1[15:0], g[15:0]};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_ENABLE) eq_on = data[0];
        else if (idx <= 3'd6) band_coef[idx - REG_BAND0] = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_word(logic [23:0] l, logic [23:0] r, logic e,
                            bit typed, logic [23:0] el, logic [23:0] er);
        stereo_t w;
        stereo_t p;
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        end_of_block <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        w.l = l;
        w.r = r;
        w.eob = e;
        p = predict_eq(w);
        if (typed && (p.l !== el || p.r !== er))
            $display("note: typed expectation differs from prediction");
        if (typed) begin
            p.l = el;
            p.r = er;
        end
        pending_words.push_back(p);
        words_sent++;
    endtask

    always @(posedge clk) begin
        stereo_t e;
        if (rst_n) begin
            out_ready <= ($urandom_range(99) >= rcv_idle);
            if (out_valid && out_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected word: left %h right %h", left_out, right_out);
                    errors++;
                end else begin
                    e = pending_words.pop_front();
                    words_checked++;
                    if (left_out !== e.l) begin
                        $error("left_out: expected %h, got %h", e.l, left_out);
                        errors++;
                    end
                    if (right_out !== e.r) begin
                        $error("right_out: expected %h, got %h", e.r, right_out);
                        errors++;
                    end
                    if (end_of_block_out !== e.eob) begin
                        $error("end_of_block_out: expected %b, got %b", e.eob,
                               end_of_block_out);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic random_phase(int n, bit small_amp);
        logic [23:0] l, r;
        for (int i = 0; i < n; i++) begin
            if (words_sent < 600) begin
                snd_idle = 16;
                rcv_idle = 51;
            end else if (words_sent < 1150) begin
                snd_idle = 51;
                rcv_idle = 16;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            if (i == n / 2) drain_words();
            l = $urandom;
            r = $urandom;
            if (small_amp && $urandom_range(3) != 0) begin
                l = 24'(signed'(l[15:0]));
                r = 24'(signed'(r[15:0]));
            end
            put_word(l, r, ($urandom_range(15) == 0), 1'b0, '0, '0);
        end
        drain_words();
    endtask

    row_t rows[$];

    function automatic row_t reg_row(logic [2:0] idx, logic [63:0] data);
        row_t t;
        t = '{ROW_REG, idx, data, '0, '0, 1'b0, 1'b0, '0, '0};
        return t;
    endfunction

    function automatic row_t word_row(logic [23:0] l, logic [23:0] r, logic e,
                                      bit typed, logic [23:0] el, logic [23:0] er);
        row_t t;
        t = '{ROW_WORD, REG_ENABLE, '0, l, r, e, typed, el, er};
        return t;
    endfunction

    initial begin
        eq_on = 1'b0;
        foreach (band_coef[i]) band_coef[i] = '0;
        foreach (integ[i]) integ[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bypass after reset, then zero coefficients, then full-scale saturation and register edge cases.
        rows.push_back(word_row(24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 24'h7FFFFF, 24'h800000));
        rows.push_back(word_row(24'h000000, 24'hFFFFFF, 1'b1, 1'b1, 24'h000000, 24'hFFFFFF));
        rows.push_back(word_row(24'h800000, 24'h7FFFFF, 1'b1, 1'b1, 24'h800000, 24'h7FFFFF));
        rows.push_back(reg_row(REG_ENABLE, 64'h1));
        rows.push_back(word_row(24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 24'h7FFFFF, 24'h800000));
        rows.push_back(word_row(24'h123456, 24'hABCDEF, 1'b1, 1'b1, 24'h123456, 24'hABCDEF));
        rows.push_back(reg_row(REG_BAND0, 64'h7FFF_C000_1800_2000));
        rows.push_back(word_row(24'h7FFFFF, 24'h800000, 1'b0, 1'b0, '0, '0));
        rows.push_back(word_row(24'h7FFFFF, 24'h800000, 1'b0, 1'b0, '0, '0));
        rows.push_back(word_row(24'h000000, 24'h000000, 1'b1, 1'b0, '0, '0));
        rows.push_back(reg_row(REG_BAND0 + 3'd5, '1));
        rows.push_back(word_row(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, '0, '0));
        rows.push_back(word_row(24'h800000, 24'h800000, 1'b1, 1'b0, '0, '0));
        rows.push_back(reg_row(REG_SPARE, '1));
        rows.push_back(word_row(24'h400000, 24'hC00000, 1'b0, 1'b0, '0, '0));
        rows.push_back(reg_row(REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE));
        rows.push_back(word_row(24'h555555, 24'hAAAAAA, 1'b1, 1'b1, 24'h555555, 24'hAAAAAA));
        rows.push_back(reg_row(REG_ENABLE, 64'h1));
        rows.push_back(word_row(24'h000001, 24'hFFFFFF, 1'b0, 1'b0, '0, '0));
        rows.push_back(word_row(24'h7FFFFF, 24'h800000, 1'b0, 1'b0, '0, '0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG) begin
                drain_words();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                put_word(rows[i].l, rows[i].r, rows[i].eob, rows[i].typed,
                         rows[i].el, rows[i].er);
            end
        end
        drain_words();

        for (int b = 0; b < NBANDS; b++) write_reg(REG_BAND0 + 3'(b), audio_coef());
        random_phase(450, 1'b1);
        for (int b = 0; b < NBANDS; b++) write_reg(REG_BAND0 + 3'(b), audio_coef());
        write_reg(REG_SPARE, {$urandom, $urandom});
        random_phase(450, 1'b0);
        for (int b = 0; b < NBANDS; b++) write_reg(REG_BAND0 + 3'(b), {$urandom, $urandom});
        random_phase(300, 1'b0);
        for (int b = 0; b < NBANDS; b++) write_reg(REG_BAND0 + 3'(b), audio_coef());
        write_reg(REG_ENABLE, 64'h0);
        random_phase(200, 1'b0);
        write_reg(REG_ENABLE, 64'h1);
        random_phase(230, 1'b1);

        repeat (200) @(posedge clk);
        $display("Sent %0d stereo words and checked %0d, across bypass, zero, extreme",
                 words_sent, words_checked);
        $display("and random band coefficients with stalls on both sides.");
        if (errors == 0 && pending_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
